// File: design/oplx_pkg.sv
package oplx_pkg;

  localparam int NUM_OPS     = 47;
  localparam int OP_MAXLEN   = 4;
  localparam int TOK_W       = 6;
  localparam int POS_W       = 2;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [7:0]         char_t;
  typedef logic [TOK_W-1:0]   tok_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [NUM_OPS-1:0] opvec_t;

  // per-position hit vectors of one classified item
  typedef struct packed {
    logic                   eoi;
    opvec_t [OP_MAXLEN-1:0] hit;
  } class_t;

  typedef struct packed {
    logic matching;
    tok_t first;
    tok_t stop;
    pos_t pos;
  } lex_state_t;

  localparam lex_state_t LEX_IDLE = '{matching: 1'b0, first: '0, stop: '0, pos: '0};

  // operator strings, left justified, zero padded
  localparam logic [OP_MAXLEN*8-1:0] OP_TEXT [NUM_OPS] = '{
    32'h2100_0000, 32'h213D_0000, 32'h2500_0000, 32'h253D_0000,
    32'h2600_0000, 32'h2626_0000, 32'h263D_0000, 32'h2800_0000,
    32'h2900_0000, 32'h2A00_0000, 32'h2A3D_0000, 32'h2B00_0000,
    32'h2B2B_0000, 32'h2B3D_0000, 32'h2C00_0000, 32'h2D00_0000,
    32'h2D2D_0000, 32'h2D3D_0000, 32'h2E00_0000, 32'h2F00_0000,
    32'h2F3D_0000, 32'h3A00_0000, 32'h3B00_0000, 32'h3C00_0000,
    32'h3C2D_0000, 32'h3C3C_0000, 32'h3C3C_3D00, 32'h3C3D_0000,
    32'h3D00_0000, 32'h3D3D_0000, 32'h3E00_0000, 32'h3E3D_0000,
    32'h3E3E_0000, 32'h3E3E_3D00, 32'h3E3E_3E00, 32'h3E3E_3E3D,
    32'h3F00_0000, 32'h5B00_0000, 32'h5D00_0000, 32'h5E00_0000,
    32'h5E3D_0000, 32'h7B00_0000, 32'h7C00_0000, 32'h7C3D_0000,
    32'h7C7C_0000, 32'h7D00_0000, 32'h7E00_0000
  };

  function automatic char_t op_char(int idx, int pos);
    return OP_TEXT[idx][(OP_MAXLEN-1-pos)*8 +: 8];
  endfunction

  // lowest set bit, NUM_OPS when none
  function automatic tok_t first_set(logic [NUM_OPS:0] v);
    tok_t r;
    r = tok_t'(NUM_OPS);
    for (int i = NUM_OPS; i >= 0; i--) begin
      if (v[i]) r = tok_t'(i);
    end
    return r;
  endfunction

endpackage

// File: design/oplx_front.sv
module oplx_front
  import oplx_pkg::*;
(
  input  char_t  char_byte,
  input  logic   end_of_input,
  output class_t cls
);

  // compare the byte against every table column at once
  always_comb begin
    cls.eoi = end_of_input;
    for (int p = 0; p < OP_MAXLEN; p++) begin
      for (int i = 0; i < NUM_OPS; i++) begin
        cls.hit[p][i] = (char_byte != 8'h00) && (op_char(i, p) == char_byte);
      end
    end
  end

endmodule

// File: design/oplx_queue.sv
module oplx_queue
  import oplx_pkg::*;
#(
  parameter int Width = 8,
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [Width-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_pop,
  output logic [Width-1:0] rd_data
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             push, pop;

  assign wr_ready = (count_r != CntW'(Depth));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: design/oplx_back.sv
module oplx_back
  import oplx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  class_t     q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output tok_t       out_token_index,
  output logic       out_byte_consumed,
  output logic       out_bad_start,
  output lex_state_t lex_state
);

  lex_state_t     st_r, st_nxt;
  logic           out_valid_r;
  tok_t           tok_r;
  logic           used_r, bad_r;

  pos_t           pos;
  tok_t           first, stop, lo, hi, pend_tok;
  opvec_t         mask, m;
  logic [NUM_OPS:0] above;
  logic           uniq;
  logic           res_valid, res_used, res_bad;
  tok_t           res_tok;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    pos   = st_r.matching ? st_r.pos   : '0;
    first = st_r.matching ? st_r.first : '0;
    stop  = st_r.matching ? st_r.stop  : tok_t'(NUM_OPS);
    if (stop > tok_t'(NUM_OPS)) stop = tok_t'(NUM_OPS);
    if (first > stop) first = stop;
    for (int i = 0; i < NUM_OPS; i++) begin
      mask[i] = (tok_t'(i) >= first) && (tok_t'(i) < stop);
    end
    m = q_data.hit[pos] & mask;
    lo = first_set({1'b0, m});
    for (int i = 0; i <= NUM_OPS; i++) begin
      above[i] = (tok_t'(i) > lo);
    end
    hi   = first_set(~{1'b0, m} & above);
    uniq = ({1'b0, hi} == ({1'b0, lo} + 7'd1));
    pend_tok = (st_r.first < tok_t'(NUM_OPS)) ? st_r.first : '0;
  end

  always_comb begin
    st_nxt    = st_r;
    res_valid = 1'b0;
    res_tok   = '0;
    res_used  = 1'b0;
    res_bad   = 1'b0;
    if (q_pop) begin
      if (q_data.eoi) begin
        if (st_r.matching) begin
          st_nxt    = LEX_IDLE;
          res_valid = 1'b1;
          res_tok   = pend_tok;
        end
      end else if (m == '0) begin
        res_valid = 1'b1;
        if (!st_r.matching) begin
          res_used = 1'b1;
          res_bad  = 1'b1;
        end else begin
          st_nxt  = LEX_IDLE;
          res_tok = (first < tok_t'(NUM_OPS)) ? first : '0;
        end
      end else if (uniq) begin
        st_nxt    = LEX_IDLE;
        res_valid = 1'b1;
        res_tok   = lo;
        res_used  = 1'b1;
      end else begin
        st_nxt = '{matching: 1'b1, first: lo, stop: hi, pos: pos + 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= LEX_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (!out_valid_r || out_ready) begin
        out_valid_r <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      tok_r  <= res_tok;
      used_r <= res_used;
      bad_r  <= res_bad;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_token_index   = tok_r;
  assign out_byte_consumed = used_r;
  assign out_bad_start     = bad_r;
  assign lex_state         = st_r;

endmodule

// File: design/operator_longest_match_lexer.sv
// Longest-match lexer for Java-style operator and punctuation tokens.
// Input channel (in_valid/in_ready): one character byte per item, or an
// end-of-input marker that closes a pending token.
// Output channel (out_valid/out_ready): a token index 0..46 in sorted table
// order, a consumed flag (0 means the byte must be offered again) and a
// bad-start flag for a byte that begins no operator while idle.
// Items that only extend a pending match, and end-of-input while idle,
// produce no output item.
// A result passes through the classifier queue, then the match unit's output
// register. Throughput: one item per cycle while the receiver does not stall;
// all table entries are compared at once in the classifier, and the match unit
// narrows the range combinationally.
// A stalled receiver holds the output register; the queue keeps taking items
// until it fills, then in_ready drops.
// Reset (rst_n low, synchronous) empties the queue and output register and
// returns the matcher to idle.
module operator_longest_match_lexer
  import oplx_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_byte,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] out_token_index,
  output logic       out_byte_consumed,
  output logic       out_bad_start
);

  localparam int ClsW = $bits(class_t);

  class_t          cls;
  class_t          q_cls;
  logic [ClsW-1:0] q_rd_data;
  logic            q_valid, q_pop;
  lex_state_t      lex_state;

  oplx_front u_front (
    .char_byte    (in_char_byte),
    .end_of_input (in_end_of_input),
    .cls          (cls)
  );

  oplx_queue #(
    .Width (ClsW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_data  (cls),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_data  (q_rd_data)
  );

  assign q_cls = class_t'(q_rd_data);

  oplx_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_data            (q_cls),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_token_index   (out_token_index),
    .out_byte_consumed (out_byte_consumed),
    .out_bad_start     (out_bad_start),
    .lex_state         (lex_state)
  );

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !lex_state.matching |->
      (lex_state.pos == '0) && (lex_state.first == '0) && (lex_state.stop == '0))
    else $error("idle matcher holds stale range");

  a_range_wide: assert property (@(posedge clk) disable iff (!rst_n)
    lex_state.matching |->
      (lex_state.stop <= tok_t'(NUM_OPS)) &&
      (({1'b0, lex_state.first} + 7'd2) <= {1'b0, lex_state.stop}))
    else $error("pending range is not ambiguous");

  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_start |-> out_byte_consumed && (out_token_index == '0))
    else $error("bad start item malformed");

  a_tok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_token_index < tok_t'(NUM_OPS)))
    else $error("token index out of table");

endmodule

// File: sim/tb_operator_longest_match_lexer.sv
module tb_operator_longest_match_lexer;

  timeunit 1ns;
  timeprecision 1ps;

  import oplx_pkg::*;

  typedef struct {
    tok_t tok;
    bit   used;
    bit   bad;
  } lexeme_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_byte = 8'h00;
  logic       in_end_of_input = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [5:0] out_token_index;
  logic       out_byte_consumed;
  logic       out_bad_start;

  // sorted operator table
  string op_tbl [NUM_OPS] = '{
    "!", "!=", "%", "%=", "&", "&&", "&=", "(", ")", "*", "*=", "+", "++",
    "+=", ",", "-", "--", "-=", ".", "/", "/=", ":", ";", "<", "<-", "<<",
    "<<=", "<=", "=", "==", ">", ">=", ">>", ">>=", ">>>", ">>>=", "?", "[",
    "]", "^", "^=", "{", "|", "|=", "||", "}", "~"
  };

  bit      lx_matching;
  int      lx_first;
  int      lx_stop;
  int      lx_pos;
  lexeme_t tokens_due [$];
  int      items_sent;
  int      err_cnt;
  int      gap_pct;
  int      stall_pct;

  operator_longest_match_lexer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_byte      (in_char_byte),
    .in_end_of_input   (in_end_of_input),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_token_index   (out_token_index),
    .out_byte_consumed (out_byte_consumed),
    .out_bad_start     (out_bad_start)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bit op_hit(int idx, int p, int ch);
    if (idx >= NUM_OPS || p >= OP_MAXLEN || ch == 0) return 1'b0;
    if (p >= op_tbl[idx].len()) return 1'b0;
    return int'(8'(op_tbl[idx][p])) == ch;
  endfunction

  function automatic void lex_idle();
    lx_matching = 1'b0;
    lx_first = 0;
    lx_stop = 0;
    lx_pos = 0;
  endfunction

  function automatic void push_token(int tok, bit used, bit bad);
    lexeme_t r;
    r.tok = tok_t'(tok);
    r.used = used;
    r.bad = bad;
    tokens_due.push_back(r);
  endfunction

  // advances the token recognizer by one item, returns 1 when the byte is handed back
  function automatic bit lex_step(int ch, bit eoi);
    int first, stop, p, lo, hi;
    if (eoi) begin
      if (lx_matching) begin
        push_token((lx_first < NUM_OPS) ? lx_first : 0, 1'b0, 1'b0);
        lex_idle();
      end
      return 1'b0;
    end
    if (lx_matching) begin
      first = lx_first;
      stop = lx_stop;
      p = lx_pos & 3;
    end else begin
      first = 0;
      stop = NUM_OPS;
      p = 0;
    end
    if (stop > NUM_OPS) stop = NUM_OPS;
    if (first > stop) first = stop;
    lo = first;
    while (lo < stop && !op_hit(lo, p, ch)) lo++;
    if (lo == stop) begin
      if (!lx_matching) begin
        push_token(0, 1'b1, 1'b1);
        return 1'b0;
      end
      lex_idle();
      push_token((first < NUM_OPS) ? first : 0, 1'b0, 1'b0);
      return 1'b1;
    end
    hi = lo;
    while (hi < stop && op_hit(hi, p, ch)) hi++;
    if (hi == lo + 1) begin
      lex_idle();
      push_token(lo, 1'b1, 1'b0);
      return 1'b0;
    end
    lx_matching = 1'b1;
    lx_first = lo;
    lx_stop = hi;
    lx_pos = (p + 1) & 3;
    return 1'b0;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    lexeme_t w;
    if (rst_n && out_valid && out_ready) begin
      if (tokens_due.size() == 0) begin
        report_mismatch("unexpected item, token", out_token_index, -1);
      end else begin
        w = tokens_due.pop_front();
        if (out_token_index !== w.tok)
          report_mismatch("token_index", out_token_index, w.tok);
        if (out_byte_consumed !== w.used)
          report_mismatch("byte_consumed", out_byte_consumed, w.used);
        if (out_bad_start !== w.bad)
          report_mismatch("bad_start", out_bad_start, w.bad);
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(input int ch, input bit eoi, output bit handed_back);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_byte <= 8'(ch);
    in_end_of_input <= eoi;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    handed_back = lex_step(ch, eoi);
  endtask

  // offers a character again while the block hands it back
  task automatic send_char(input int ch);
    bit again;
    do send_item(ch, 1'b0, again); while (again);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(int'(8'(s[i])));
  endtask

  task automatic send_eoi(input int ch);
    bit again;
    send_item(ch, 1'b1, again);
  endtask

  task automatic test_operator_extremes();
    send_text(">>>=");
    send_text("<-");
    send_text("<<=");
    send_text("!=");
    send_text("&&");
    send_text("||");
    send_text("~");
    send_text("!");
    send_eoi(8'hFF);
  endtask

  task automatic test_special_bytes();
    bit again;
    send_char(8'hFF);
    send_char(8'h00);
    send_eoi(8'h00);
    send_text(">");
    send_item(8'h00, 1'b0, again);
    send_char(8'h00);
  endtask

  task automatic test_random_stream(input int n_items, input int snd_pct, input int rcv_pct);
    int target, kind;
    bit again;
    gap_pct = snd_pct;
    stall_pct = rcv_pct;
    target = items_sent + n_items;
    while (items_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        send_text(op_tbl[$urandom_range(NUM_OPS-1)]);
      end else if (kind < 78) begin
        send_eoi($urandom_range(255));
      end else if (kind < 90) begin
        send_char($urandom_range(255));
      end else if (kind < 95) begin
        // broken sequence: a handed-back byte is not offered again
        send_item($urandom_range(255), 1'b0, again);
      end else begin
        send_char(($urandom_range(1) == 1) ? 8'hFF : 8'h00);
      end
    end
  endtask

  task automatic test_drain_pause();
    test_random_stream(120, 0, 50);
    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    lex_idle();
    items_sent = 0;
    err_cnt = 0;
    gap_pct = 0;
    stall_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_operator_extremes();
    test_special_bytes();
    test_random_stream(450, 0, 0);
    test_random_stream(300, 87, 0);
    test_drain_pause();
    test_random_stream(300, 0, 87);
    test_random_stream(350, 12, 12);
    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[operator_longest_match_lexer] OK");
    end else begin
      $display("[operator_longest_match_lexer] ERROR");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("timeout, %0d results still due", tokens_due.size());
    $display("[operator_longest_match_lexer] ERROR");
    $finish;
  end

endmodule
